/* hdl/hfd_pkg.sv */
// hfd_pkg: shared types and constants for the huffman tree bit decoder
`timescale 1ns / 1ps
`default_nettype none
package hfd_pkg;

    // tree size
    localparam int MAX_SYMBOLS = 256;
    localparam int NODE_SLOTS  = 2 * MAX_SYMBOLS - 1;
    localparam int IDX_W       = $clog2(NODE_SLOTS + 1);
    localparam int SYM_W       = 8;

    // item operation codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // code bit meaning
    localparam logic BIT_LEFT  = 1'b0;

    // one node of the tree table
    typedef struct packed {
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
        logic             leaf;
        logic [SYM_W-1:0] sym;
    } node_t;

    // one input beat as held in the input register
    typedef struct packed {
        logic             op;
        logic [IDX_W-1:0] node_index;
        logic [IDX_W-1:0] left_child;
        logic [IDX_W-1:0] right_child;
        logic             is_leaf;
        logic [SYM_W-1:0] leaf_symbol;
        logic             code_bit;
    } item_t;

endpackage
`default_nettype wire

/* hdl/hfd_in_stage.sv */
// hfd_in_stage: input register that holds one beat until the walker takes it
`timescale 1ns / 1ps
`default_nettype none
module hfd_in_stage (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        op,
    input  wire logic [hfd_pkg::IDX_W-1:0]   node_index,
    input  wire logic [hfd_pkg::IDX_W-1:0]   left_child,
    input  wire logic [hfd_pkg::IDX_W-1:0]   right_child,
    input  wire logic                        is_leaf,
    input  wire logic [hfd_pkg::SYM_W-1:0]   leaf_symbol,
    input  wire logic                        code_bit,
    input  wire logic                        take,
    output logic                             item_valid,
    output hfd_pkg::item_t                   item
);

    logic           valid_reg;
    logic           valid_next;
    hfd_pkg::item_t item_reg;
    logic           accept;

    // stall while a held beat is not being taken this cycle
    assign in_stall = valid_reg && !take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.op          <= op;
            item_reg.node_index  <= node_index;
            item_reg.left_child  <= left_child;
            item_reg.right_child <= right_child;
            item_reg.is_leaf     <= is_leaf;
            item_reg.leaf_symbol <= leaf_symbol;
            item_reg.code_bit    <= code_bit;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule
`default_nettype wire

/* hdl/hfd_walk.sv */
// hfd_walk: node table, cached current and root nodes, walk control and result register
`timescale 1ns / 1ps
`default_nettype none
module hfd_walk (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        item_valid,
    input  wire hfd_pkg::item_t              item,
    output logic                             take,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [hfd_pkg::IDX_W-1:0]   cfg_data,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [hfd_pkg::SYM_W-1:0]        symbol
);

    localparam logic [1:0] S_RUN    = 2'd0;
    localparam logic [1:0] S_FETCH  = 2'd1;
    localparam logic [1:0] S_RELOAD = 2'd2;

    // node table
    hfd_pkg::node_t mem [0:hfd_pkg::NODE_SLOTS-1];

    logic [1:0]                state_reg, state_next;
    logic [hfd_pkg::IDX_W-1:0] root_reg, root_next;
    logic [hfd_pkg::IDX_W-1:0] cur_node_reg, cur_node_next;
    logic [hfd_pkg::IDX_W-1:0] next_node_reg, next_node_next;
    hfd_pkg::node_t            root_entry_reg, root_entry_next;
    hfd_pkg::node_t            cur_entry_reg, cur_entry_next;
    logic                      out_valid_reg, out_valid_next;
    logic [hfd_pkg::SYM_W-1:0] symbol_reg, symbol_next;
    hfd_pkg::node_t            rd_data_reg;

    logic                      wr_en;
    logic [hfd_pkg::IDX_W-1:0] wr_addr;
    hfd_pkg::node_t            wr_data;
    logic                      rd_en;
    logic [hfd_pkg::IDX_W-1:0] rd_addr;
    logic                      out_free;
    logic                      emit;
    logic [hfd_pkg::IDX_W-1:0] child_idx;

    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = (state_reg == S_RUN) && !item_valid;
    assign child_idx = (item.code_bit == hfd_pkg::BIT_LEFT) ? cur_entry_reg.left
                                                             : cur_entry_reg.right;

    // write beat as a node word
    always_comb
    begin
        wr_addr       = item.node_index;
        wr_data.left  = item.left_child;
        wr_data.right = item.right_child;
        wr_data.leaf  = item.is_leaf;
        wr_data.sym   = item.leaf_symbol;
    end

    // walk control
    always_comb
    begin
        state_next      = state_reg;
        root_next       = root_reg;
        cur_node_next   = cur_node_reg;
        next_node_next  = next_node_reg;
        root_entry_next = root_entry_reg;
        cur_entry_next  = cur_entry_reg;
        take            = 1'b0;
        emit            = 1'b0;
        symbol_next     = symbol_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = child_idx;

        case (state_reg)
            S_RUN:
            begin
                if (cfg_valid && cfg_ready)
                begin
                    // new root: drop the partial code and load the root node
                    root_next     = cfg_data;
                    cur_node_next = cfg_data;
                    rd_en         = 1'b1;
                    rd_addr       = cfg_data;
                    state_next    = S_RELOAD;
                end
                else if (item_valid)
                begin
                    if (item.op == hfd_pkg::OP_WRITE)
                    begin
                        take  = 1'b1;
                        wr_en = ({1'b0, item.node_index} <
                                 (hfd_pkg::IDX_W + 1)'(hfd_pkg::NODE_SLOTS));
                        // keep cached nodes in step with the table
                        if (wr_en && item.node_index == root_reg)
                        begin
                            root_entry_next = wr_data;
                        end
                        if (wr_en && item.node_index == cur_node_reg)
                        begin
                            cur_entry_next = wr_data;
                        end
                    end
                    else if (cur_entry_reg.leaf)
                    begin
                        // current node is a leaf: emit it when the output is free and return to the root
                        if (out_free)
                        begin
                            take           = 1'b1;
                            emit           = 1'b1;
                            symbol_next    = cur_entry_reg.sym;
                            cur_node_next  = root_reg;
                            cur_entry_next = root_entry_reg;
                        end
                    end
                    else
                    begin
                        // step to a child: fetch its node
                        rd_en          = 1'b1;
                        next_node_next = child_idx;
                        state_next     = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                if (rd_data_reg.leaf)
                begin
                    if (out_free)
                    begin
                        take           = 1'b1;
                        emit           = 1'b1;
                        symbol_next    = rd_data_reg.sym;
                        cur_node_next  = root_reg;
                        cur_entry_next = root_entry_reg;
                        state_next     = S_RUN;
                    end
                end
                else
                begin
                    take           = 1'b1;
                    cur_node_next  = next_node_reg;
                    cur_entry_next = rd_data_reg;
                    state_next     = S_RUN;
                end
            end
            S_RELOAD:
            begin
                root_entry_next = rd_data_reg;
                cur_entry_next  = rd_data_reg;
                state_next      = S_RUN;
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control and cached state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_RUN;
            root_reg       <= '0;
            cur_node_reg   <= '0;
            next_node_reg  <= '0;
            root_entry_reg <= '0;
            cur_entry_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            root_reg       <= root_next;
            cur_node_reg   <= cur_node_next;
            next_node_reg  <= next_node_next;
            root_entry_reg <= root_entry_next;
            cur_entry_reg  <= cur_entry_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        symbol_reg <= symbol_next;
    end

    // table write port and registered read port, out-of-table reads give zero
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            if ({1'b0, rd_addr} < (hfd_pkg::IDX_W + 1)'(hfd_pkg::NODE_SLOTS))
            begin
                rd_data_reg <= mem[rd_addr];
            end
            else
            begin
                rd_data_reg <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign symbol    = symbol_reg;

`ifndef ASSERT_OFF
    a_cfg_reload: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> state_reg == S_RELOAD)
        else $error("root write did not start a reload");

    a_reload_short: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RELOAD |=> state_reg == S_RUN)
        else $error("reload lasted more than one cycle");

    a_emit_to_root: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> cur_node_reg == $past(root_reg) && out_valid_reg)
        else $error("walk did not return to root after a symbol");

    a_fetch_has_decode: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FETCH |-> item_valid && item.op == hfd_pkg::OP_DECODE)
        else $error("child fetch without a held decode beat");
`endif

endmodule
`default_nettype wire

/* hdl/huffman_tree_bit_decoder.sv */
// A decode beat whose current node is a leaf shows its symbol through the result register;
// a beat that steps to a child first waits for one node table read.
// Node writes and leaf-at-current bits are taken straight from the input register, while
// child steps wait for the registered read of the node table port.
// Reset clears control, root and current node to 0; a root write then passes through a
// reload state that reads the new root node, while input beats wait.
`timescale 1ns / 1ps
`default_nettype none
module huffman_tree_bit_decoder (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        op,
    input  wire logic [hfd_pkg::IDX_W-1:0]   node_index,
    input  wire logic [hfd_pkg::IDX_W-1:0]   left_child,
    input  wire logic [hfd_pkg::IDX_W-1:0]   right_child,
    input  wire logic                        is_leaf,
    input  wire logic [hfd_pkg::SYM_W-1:0]   leaf_symbol,
    input  wire logic                        code_bit,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [hfd_pkg::SYM_W-1:0]        symbol,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [hfd_pkg::IDX_W-1:0]   cfg_data
);

    logic           item_valid;
    hfd_pkg::item_t item;
    logic           take;

    // input register
    hfd_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .node_index  (node_index),
        .left_child  (left_child),
        .right_child (right_child),
        .is_leaf     (is_leaf),
        .leaf_symbol (leaf_symbol),
        .code_bit    (code_bit),
        .take        (take),
        .item_valid  (item_valid),
        .item        (item)
    );

    // tree walk and result register
    hfd_walk u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .symbol     (symbol)
    );

endmodule
`default_nettype wire

/* test/tb_huffman_tree_bit_decoder.sv */
// testbench for the huffman tree bit decoder: directed rows, random trees, symbol scoreboard
`timescale 1ns / 1ps
module tb_huffman_tree_bit_decoder;

    localparam int ITEM_TARGET = 1050;
    localparam int TAIL_ITEMS  = 150;
    localparam int HOLD_AT     = 400;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 8;
    localparam int MAX_PRINTS  = 20;

    localparam logic BIT_RIGHT = ~hfd_pkg::BIT_LEFT;
    localparam logic LEAF      = 1'b1;
    localparam logic INNER     = 1'b0;
    // one past the last table slot: writes are dropped, reads give an inner node
    localparam logic [hfd_pkg::IDX_W-1:0] NO_SLOT = '1;

    // how a directed row is checked
    typedef enum logic [1:0] {CHK_PRED, CHK_SYM, CHK_QUIET} chk_t;
    typedef enum logic {ROW_BEAT, ROW_ROOT} row_kind_t;

    typedef struct {
        row_kind_t                     kind;
        hfd_pkg::item_t                it;
        logic [hfd_pkg::IDX_W-1:0]     root;
        chk_t                          chk;
        logic [hfd_pkg::SYM_W-1:0]     sym;
    } dir_row_t;

    // block ports
    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    hfd_pkg::item_t            beat      = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [hfd_pkg::SYM_W-1:0] symbol;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [hfd_pkg::IDX_W-1:0] cfg_data  = '0;

    // predicted tree state
    hfd_pkg::node_t            tree_mem [hfd_pkg::NODE_SLOTS];
    bit                        is_written [hfd_pkg::NODE_SLOTS];
    logic [hfd_pkg::IDX_W-1:0] written_list [$];
    logic [hfd_pkg::IDX_W-1:0] root_reg = '0;
    logic [hfd_pkg::IDX_W-1:0] walk_pos = '0;
    logic [hfd_pkg::SYM_W-1:0] sym_q [$];

    // run bookkeeping
    int err_count = 0;
    int n_items   = 0;
    int n_writes  = 0;
    int n_bits    = 0;
    int n_roots   = 0;
    int n_syms    = 0;
    bit idle_on   = 1'b0;
    bit hold_go   = 1'b0;
    bit hold_done = 1'b0;

    always #5 clk = ~clk;

    huffman_tree_bit_decoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (beat.op),
        .node_index  (beat.node_index),
        .left_child  (beat.left_child),
        .right_child (beat.right_child),
        .is_leaf     (beat.is_leaf),
        .leaf_symbol (beat.leaf_symbol),
        .code_bit    (beat.code_bit),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .symbol      (symbol),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    task automatic flag_error(input string what);
        if (err_count < MAX_PRINTS)
            $display("mismatch at %0t ns: %s", $time, what);
        err_count++;
    endtask

    // table read: slots past the end read as an inner node linking to 0
    function automatic hfd_pkg::node_t fetch_node(input logic [hfd_pkg::IDX_W-1:0] idx);
        if (idx < hfd_pkg::NODE_SLOTS)
            return tree_mem[idx];
        return '0;
    endfunction

    // one code bit of the walk: emit on a leaf at the current node or at the child
    task automatic walk_bit(input logic cb, output bit hit,
                            output logic [hfd_pkg::SYM_W-1:0] sym);
        hfd_pkg::node_t            here;
        hfd_pkg::node_t            there;
        logic [hfd_pkg::IDX_W-1:0] nxt;
        hit  = 1'b0;
        sym  = '0;
        here = fetch_node(walk_pos);
        if (here.leaf) begin
            hit      = 1'b1;
            sym      = here.sym;
            walk_pos = root_reg;
        end
        else begin
            nxt   = (cb == hfd_pkg::BIT_LEFT) ? here.left : here.right;
            there = fetch_node(nxt);
            if (there.leaf) begin
                hit      = 1'b1;
                sym      = there.sym;
                walk_pos = root_reg;
            end
            else begin
                walk_pos = nxt;
            end
        end
    endtask

    function automatic hfd_pkg::item_t rand_item();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[$bits(hfd_pkg::item_t)-1:0];
    endfunction

    // link target: a written slot, or sometimes the slot past the table
    function automatic logic [hfd_pkg::IDX_W-1:0] pick_link();
        if ($urandom_range(0, 7) == 0)
            return NO_SLOT;
        return written_list[$urandom_range(0, written_list.size() - 1)];
    endfunction

    function automatic dir_row_t node_row(input logic [hfd_pkg::IDX_W-1:0] idx,
                                          input logic [hfd_pkg::IDX_W-1:0] l,
                                          input logic [hfd_pkg::IDX_W-1:0] r,
                                          input logic lf,
                                          input logic [hfd_pkg::SYM_W-1:0] s);
        dir_row_t row;
        row.kind           = ROW_BEAT;
        row.it             = rand_item();
        row.it.op          = hfd_pkg::OP_WRITE;
        row.it.node_index  = idx;
        row.it.left_child  = l;
        row.it.right_child = r;
        row.it.is_leaf     = lf;
        row.it.leaf_symbol = s;
        row.root           = '0;
        row.chk            = CHK_PRED;
        row.sym            = '0;
        return row;
    endfunction

    function automatic dir_row_t bit_row(input logic cb, input chk_t chk,
                                         input logic [hfd_pkg::SYM_W-1:0] s);
        dir_row_t row;
        row.kind        = ROW_BEAT;
        row.it          = rand_item();
        row.it.op       = hfd_pkg::OP_DECODE;
        row.it.code_bit = cb;
        row.root        = '0;
        row.chk         = chk;
        row.sym         = s;
        return row;
    endfunction

    function automatic dir_row_t root_row(input logic [hfd_pkg::IDX_W-1:0] v);
        dir_row_t row;
        row.kind = ROW_ROOT;
        row.it   = '0;
        row.root = v;
        row.chk  = CHK_PRED;
        row.sym  = '0;
        return row;
    endfunction

    // offer one beat, wait for it to be taken, then update the prediction
    task automatic drive_item(input hfd_pkg::item_t it, input chk_t chk,
                              input logic [hfd_pkg::SYM_W-1:0] want);
        bit                        hit;
        logic [hfd_pkg::SYM_W-1:0] got_sym;
        hit     = 1'b0;
        got_sym = '0;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        beat     <= it;
        do @(posedge clk); while (in_stall !== 1'b0);
        n_items++;
        if (it.op == hfd_pkg::OP_WRITE) begin
            n_writes++;
            if (it.node_index < hfd_pkg::NODE_SLOTS) begin
                tree_mem[it.node_index] = {it.left_child, it.right_child,
                                           it.is_leaf, it.leaf_symbol};
                if (!is_written[it.node_index]) begin
                    is_written[it.node_index] = 1'b1;
                    written_list.push_back(it.node_index);
                end
            end
        end
        else begin
            n_bits++;
            walk_bit(it.code_bit, hit, got_sym);
        end
        // typed rows override the predictor
        if (chk == CHK_SYM) begin
            hit     = 1'b1;
            got_sym = want;
        end
        else if (chk == CHK_QUIET) begin
            hit = 1'b0;
        end
        if (hit)
            sym_q.push_back(got_sym);
    endtask

    task automatic send_bit(input logic cb);
        hfd_pkg::item_t it;
        it          = rand_item();
        it.op       = hfd_pkg::OP_DECODE;
        it.code_bit = cb;
        drive_item(it, CHK_PRED, '0);
    endtask

    // stray node write, sometimes past the table; an inner node links to written slots or past the table
    task automatic noise_write();
        hfd_pkg::item_t it;
        it    = rand_item();
        it.op = hfd_pkg::OP_WRITE;
        if ($urandom_range(0, 9) == 0)
            it.node_index = NO_SLOT;
        else
            it.node_index = hfd_pkg::IDX_W'($urandom_range(0, hfd_pkg::NODE_SLOTS - 1));
        if (it.is_leaf == INNER) begin
            it.left_child  = pick_link();
            it.right_child = pick_link();
        end
        drive_item(it, CHK_PRED, '0);
    endtask

    // well-formed tree in a contiguous run of slots, children written before parents
    task automatic send_tree(input int n_sym, output logic [hfd_pkg::IDX_W-1:0] top);
        int             pool [$];
        int             nxt_slot;
        int             k;
        int             l;
        int             r;
        hfd_pkg::item_t it;
        nxt_slot = $urandom_range(0, hfd_pkg::NODE_SLOTS - (2 * n_sym - 1));
        for (k = 0; k < n_sym; k++) begin
            it            = rand_item();
            it.op         = hfd_pkg::OP_WRITE;
            it.node_index = hfd_pkg::IDX_W'(nxt_slot);
            it.is_leaf    = LEAF;
            drive_item(it, CHK_PRED, '0);
            pool.push_back(nxt_slot);
            nxt_slot++;
        end
        while (pool.size() > 1) begin
            k = $urandom_range(0, pool.size() - 1);
            l = pool[k];
            pool.delete(k);
            k = $urandom_range(0, pool.size() - 1);
            r = pool[k];
            pool.delete(k);
            it             = rand_item();
            it.op          = hfd_pkg::OP_WRITE;
            it.node_index  = hfd_pkg::IDX_W'(nxt_slot);
            it.left_child  = hfd_pkg::IDX_W'(l);
            it.right_child = hfd_pkg::IDX_W'(r);
            it.is_leaf     = INNER;
            drive_item(it, CHK_PRED, '0);
            pool.push_back(nxt_slot);
            nxt_slot++;
        end
        top = hfd_pkg::IDX_W'(pool[0]);
    endtask

    // root load only once the block has drained and settled
    task automatic set_root(input logic [hfd_pkg::IDX_W-1:0] v);
        in_valid <= 1'b0;
        while (sym_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        root_reg = v;
        walk_pos = v;
        n_roots++;
    endtask

    // output side: compare each beat, then pick the next stall value
    initial begin : sink
        int                        stall_left;
        int                        hold_left;
        logic [hfd_pkg::SYM_W-1:0] want;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid === 1'b1 && !out_stall) begin
                if (sym_q.size() == 0) begin
                    flag_error($sformatf("symbol %02h with nothing expected", symbol));
                end
                else begin
                    want = sym_q.pop_front();
                    n_syms++;
                    if (symbol !== want)
                        flag_error($sformatf("symbol %02h, expected %02h", symbol, want));
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_go) begin
                hold_go   = 1'b0;
                hold_left = LONG_HOLD - 1;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 4);
                out_stall <= 1'b1;
            end
            else begin
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // stimulus
    initial begin : source
        dir_row_t                  dir_rows [$];
        logic [hfd_pkg::IDX_W-1:0] top;
        int                        n_sym;

        // root is a leaf right after reset
        dir_rows.push_back(node_row(9'd0, 9'd0, 9'd0, LEAF, 8'hA5));
        dir_rows.push_back(bit_row(hfd_pkg::BIT_LEFT, CHK_SYM, 8'hA5));
        dir_rows.push_back(bit_row(BIT_RIGHT, CHK_SYM, 8'hA5));
        // top root with a leaf on the left and the slot past the table on the right
        dir_rows.push_back(node_row(9'd1, NO_SLOT, NO_SLOT, LEAF, 8'hFF));
        dir_rows.push_back(node_row(9'd510, 9'd1, NO_SLOT, INNER, 8'h00));
        dir_rows.push_back(node_row(NO_SLOT, 9'd0, 9'd0, LEAF, 8'h3C));
        dir_rows.push_back(root_row(9'd510));
        dir_rows.push_back(bit_row(hfd_pkg::BIT_LEFT, CHK_SYM, 8'hFF));
        dir_rows.push_back(bit_row(BIT_RIGHT, CHK_QUIET, 8'h00));
        dir_rows.push_back(bit_row(hfd_pkg::BIT_LEFT, CHK_SYM, 8'hA5));
        dir_rows.push_back(bit_row(BIT_RIGHT, CHK_QUIET, 8'h00));
        dir_rows.push_back(bit_row(BIT_RIGHT, CHK_SYM, 8'hA5));
        // node rewritten while a code is half walked
        dir_rows.push_back(node_row(9'd2, 9'd0, 9'd0, LEAF, 8'h5A));
        dir_rows.push_back(bit_row(BIT_RIGHT, CHK_QUIET, 8'h00));
        dir_rows.push_back(node_row(9'd0, 9'd0, 9'd0, LEAF, 8'h11));
        dir_rows.push_back(bit_row(hfd_pkg::BIT_LEFT, CHK_PRED, 8'h00));
        dir_rows.push_back(root_row(9'd0));
        dir_rows.push_back(bit_row(BIT_RIGHT, CHK_PRED, 8'h00));
        // root load drops a partial code
        dir_rows.push_back(node_row(9'd3, 9'd2, 9'd510, INNER, 8'h00));
        dir_rows.push_back(root_row(9'd3));
        dir_rows.push_back(bit_row(BIT_RIGHT, CHK_QUIET, 8'h00));
        dir_rows.push_back(root_row(9'd3));
        dir_rows.push_back(bit_row(hfd_pkg::BIT_LEFT, CHK_PRED, 8'h00));
        // self loop never emits until it becomes a leaf
        dir_rows.push_back(node_row(9'd4, 9'd4, 9'd4, INNER, 8'h00));
        dir_rows.push_back(root_row(9'd4));
        dir_rows.push_back(bit_row(hfd_pkg::BIT_LEFT, CHK_QUIET, 8'h00));
        dir_rows.push_back(bit_row(BIT_RIGHT, CHK_QUIET, 8'h00));
        dir_rows.push_back(node_row(9'd4, 9'h155, 9'h0AA, LEAF, 8'h77));
        dir_rows.push_back(bit_row(hfd_pkg::BIT_LEFT, CHK_PRED, 8'h00));

        // reset
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_on = 1'b1;

        // directed rows
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_ROOT)
                set_root(dir_rows[i].root);
            else
                drive_item(dir_rows[i].it, dir_rows[i].chk, dir_rows[i].sym);
        end

        // random trees and decoding, with stray writes and root moves
        while (n_items < ITEM_TARGET) begin
            if (n_items >= ITEM_TARGET - TAIL_ITEMS)
                idle_on = 1'b0;
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 11))
                    0:       n_sym = 1;
                    1:       n_sym = $urandom_range(9, 48);
                    default: n_sym = $urandom_range(2, 8);
                endcase
                send_tree(n_sym, top);
                set_root(top);
                repeat ($urandom_range(12, 40)) begin
                    // long output hold while code bits keep coming
                    if (!hold_done && n_items >= HOLD_AT) begin
                        hold_go   = 1'b1;
                        hold_done = 1'b1;
                    end
                    if ($urandom_range(0, 9) == 0)
                        noise_write();
                    else
                        send_bit(1'($urandom_range(0, 1)));
                end
            end
            else begin
                repeat ($urandom_range(8, 24)) begin
                    if ($urandom_range(0, 2) == 0)
                        noise_write();
                    else
                        send_bit(1'($urandom_range(0, 1)));
                end
                if ($urandom_range(0, 1) == 0)
                    set_root(written_list[$urandom_range(0, written_list.size() - 1)]);
            end
        end
        in_valid <= 1'b0;

        // drain and settle
        while (sym_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d beats: %0d node writes, %0d code bits, %0d root loads",
                 n_items, n_writes, n_bits, n_roots);
        $display("compared %0d decoded symbols, %0d mismatches", n_syms, err_count);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* filelist.f */
hdl/hfd_pkg.sv
hdl/hfd_in_stage.sv
hdl/hfd_walk.sv
hdl/huffman_tree_bit_decoder.sv
test/tb_huffman_tree_bit_decoder.sv
